// File: rtl/kth_smallest_select_unit_macros.svh
// assertion macros for the rank selection block
`ifndef KTH_SMALLEST_SELECT_UNIT_MACROS_SVH
`define KTH_SMALLEST_SELECT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// condition holds in the same cycle as the trigger
`define KSS_ASSERT_HOLD(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");
// condition holds in the cycle after the trigger
`define KSS_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");
`else
`define KSS_ASSERT_HOLD(label, clk, rst, trig, cond)
`define KSS_ASSERT_NEXT(label, clk, rst, trig, cond)
`endif

`endif

// File: rtl/kss_pkg.sv
`default_nettype none
package kss_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 7;
  localparam int STATUS_W      = 2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  // control broadcast to every cell
  typedef struct packed {
    logic ins;
    logic shift;
  } kss_ctl_t;

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_SCAN    = 3'b010,
    ST_OUT     = 3'b100
  } kss_state_t;

endpackage
`default_nettype wire

// File: rtl/kss_cell.sv
`default_nettype none
module kss_cell
  import kss_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire logic                      clk,
  input  wire kss_ctl_t                  ctl,
  input  wire logic [CNT_W-1:0]          count,
  input  wire logic signed [VALUE_W-1:0] new_value,
  input  wire logic signed [VALUE_W-1:0] prev_val,
  input  wire logic                      prev_lt,
  input  wire logic signed [VALUE_W-1:0] next_val,
  output logic signed [VALUE_W-1:0]      val,
  output logic                           lt
);

  localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

  logic                      take;
  logic signed [VALUE_W-1:0] val_next;

  // new value sorts before the held one
  assign lt = new_value < val;

  // occupied cells that the new value displaces, plus the first free cell
  assign take = ctl.ins && (IDX_C <= count) && ((IDX_C == count) || lt);

  always_comb begin
    if (ctl.shift) begin
      val_next = next_val;
    end else if (take) begin
      val_next = prev_lt ? prev_val : new_value;
    end else begin
      val_next = val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule
`default_nettype wire

// File: rtl/kth_smallest_select_unit.sv
// Rank selection over a streamed set of signed 32-bit values.
// Input channel: in_valid / in_stall carry value, rank and last. Each
// transfer adds value to the set; rank is read only with last = 1.
// Output channel: out_valid / out_stall carry selected and status, one
// result per set, after the transfer that carries last.
// A row of MAX_ITEMS cells keeps the set sorted; each value is placed in
// the row as it is taken, so non-last items are taken one per cycle when not stalled.
// On last with rank r in range, the row shifts toward cell 0 until the r-th
// smallest value sits in cell 0, and cell 0 is then captured as the result.
// Overflow or a bad rank gives the result in the cycle after the last transfer.
// Overflow (more than MAX_ITEMS values) drops the extra values, status 2.
// Input is stalled while the row shifts and while a result waits under
// out_stall; once the result is taken, a new set can stream in at once.
// Reset (rst, synchronous) empties the set and drops any pending result.
`default_nettype none
`include "kth_smallest_select_unit_macros.svh"
module kth_smallest_select_unit
  import kss_pkg::*;
#(
  parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic [RANK_W-1:0]         rank,
  input  wire logic                      last,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [VALUE_W-1:0]      selected,
  output logic [STATUS_W-1:0]            status
);

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W = $clog2(MAX_ITEMS);
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ITEMS);

  kss_state_t                state;
  logic [CNT_W-1:0]          count;
  logic                      overflowed;
  logic [IDX_W-1:0]          scan_cnt;

  logic                      acc_in;
  logic                      acc_out;
  logic                      full;
  logic [CNT_W-1:0]          count_next;
  logic                      ovf_next;
  logic                      rank_bad;
  logic [CMP_W-1:0]          rank_ext;
  logic [CMP_W-1:0]          count_ext;
  logic [CMP_W-1:0]          rank_m1;
  kss_ctl_t                  ctl;

  logic signed [VALUE_W-1:0] cell_val [MAX_ITEMS];
  logic                      cell_lt  [MAX_ITEMS];

  // handshakes
  assign in_stall = (state == ST_SCAN) || ((state == ST_OUT) && out_stall);
  assign acc_in   = in_valid && !in_stall;
  assign acc_out  = out_valid && !out_stall;

  // fill and rank checks for the incoming value
  assign full       = (count == MAX_C);
  assign count_next = full ? count : count + CNT_W'(1);
  assign ovf_next   = overflowed || full;
  assign rank_ext   = CMP_W'(rank);
  assign count_ext  = CMP_W'(count_next);
  assign rank_bad   = (rank_ext == '0) || (rank_ext > count_ext);
  assign rank_m1    = rank_ext - CMP_W'(1);

  // cell control
  assign ctl.ins   = acc_in && !full;
  assign ctl.shift = (state == ST_SCAN) && (scan_cnt != '0);

  // sorted row of cells
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_val;
    logic                      prev_lt;
    logic signed [VALUE_W-1:0] next_val;

    if (i == 0) begin : g_first
      assign prev_val = value;
      assign prev_lt  = 1'b0;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == MAX_ITEMS - 1) begin : g_end
      assign next_val = cell_val[i];
    end else begin : g_body
      assign next_val = cell_val[i+1];
    end

    kss_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .new_value (value),
      .prev_val  (prev_val),
      .prev_lt   (prev_lt),
      .next_val  (next_val),
      .val       (cell_val[i]),
      .lt        (cell_lt[i])
    );
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      count      <= '0;
      overflowed <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // result taken
      if (acc_out) begin
        out_valid <= 1'b0;
        state     <= ST_COLLECT;
      end

      // input transfer
      if (acc_in) begin
        if (!last) begin
          count      <= count_next;
          overflowed <= ovf_next;
        end else if (ovf_next || rank_bad) begin
          out_valid  <= 1'b1;
          count      <= '0;
          overflowed <= 1'b0;
          state      <= ST_OUT;
        end else begin
          count      <= count_next;
          overflowed <= 1'b0;
          state      <= ST_SCAN;
        end
      end

      // rank readout
      if (state == ST_SCAN && scan_cnt == '0) begin
        out_valid <= 1'b1;
        count     <= '0;
        state     <= ST_OUT;
      end
    end
  end

  // payload and scan counter
  always_ff @(posedge clk) begin
    if (acc_in && last) begin
      scan_cnt <= rank_m1[IDX_W-1:0];
      selected <= '0;
      status   <= ovf_next ? STATUS_OVERFLOW : STATUS_RANGE;
    end else if (state == ST_SCAN) begin
      if (scan_cnt == '0) begin
        selected <= cell_val[0];
        status   <= STATUS_OK;
      end else begin
        scan_cnt <= scan_cnt - IDX_W'(1);
      end
    end
  end

  // checks
  `KSS_ASSERT_HOLD(a_count_cap, clk, rst, 1'b1, count <= MAX_C)
  `KSS_ASSERT_HOLD(a_scan_no_out, clk, rst, state == ST_SCAN, !out_valid)
  `KSS_ASSERT_NEXT(a_last_moves, clk, rst, acc_in && last, out_valid || state == ST_SCAN)
  `KSS_ASSERT_NEXT(a_scan_step, clk, rst, state == ST_SCAN && scan_cnt != '0,
                   state == ST_SCAN && scan_cnt == $past(scan_cnt) - IDX_W'(1))

endmodule
`default_nettype wire

// File: dv/testbench.sv
`default_nettype none
module testbench;
  import kss_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ITEMS    = MAX_ITEMS_DEF;
  localparam int ITEM_TARGET  = 900;
  localparam int MIN_SETS     = 48;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANK_TOP     = (1 << RANK_W) - 1;

  localparam logic signed [VALUE_W-1:0] VMAX = 32'sh7fffffff;
  localparam logic signed [VALUE_W-1:0] VMIN = 32'sh80000000;

  typedef struct {
    logic signed [VALUE_W-1:0] sel;
    logic [STATUS_W-1:0]       st;
  } pick_t;

  typedef struct {
    logic signed [VALUE_W-1:0] v;
    logic [RANK_W-1:0]         r;
    bit                        l;
    bit                        typed;
    logic signed [VALUE_W-1:0] sel;
    logic [STATUS_W-1:0]       st;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value;
  logic [RANK_W-1:0]         rank;
  logic                      last;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [VALUE_W-1:0] selected;
  logic [STATUS_W-1:0]       status;

  // predictor state: the set kept in ascending order
  logic signed [VALUE_W-1:0] sorted_vals[$];
  bit                        set_overflow = 1'b0;
  pick_t                     pending_picks[$];

  int err_count   = 0;
  int items_sent  = 0;
  bit hold_req    = 1'b0;
  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;

  // directed sets; typed expectations where they are obvious
  stim_row_t dir_rows[] = '{
    '{32'sd1, 7'd1, 1'b1, 1'b1, 32'sd1, STATUS_OK},
    '{VMAX, 7'd1, 1'b1, 1'b1, VMAX, STATUS_OK},
    '{VMIN, 7'd1, 1'b1, 1'b1, VMIN, STATUS_OK},
    '{32'sd5, 7'd0, 1'b1, 1'b1, 32'sd0, STATUS_RANGE},
    '{32'sd5, 7'd2, 1'b1, 1'b1, 32'sd0, STATUS_RANGE},
    '{-32'sd1, 7'd127, 1'b1, 1'b1, 32'sd0, STATUS_RANGE},
    '{32'sd7, 7'd127, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{32'sd7, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{32'sd7, 7'd2, 1'b1, 1'b1, 32'sd7, STATUS_OK},
    '{VMAX, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{VMIN, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{32'sd0, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{-32'sd1, 7'd4, 1'b1, 1'b1, VMAX, STATUS_OK},
    '{32'sd3, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{-32'sd2, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{32'sd10, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{-32'sd2, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{32'sd0, 7'd3, 1'b1, 1'b0, 32'sd0, STATUS_OK},
    '{32'sd9, 7'd0, 1'b0, 1'b0, 32'sd0, STATUS_OK},
    '{32'sd8, 7'd64, 1'b1, 1'b1, 32'sd0, STATUS_RANGE},
    '{-32'sd100, 7'd1, 1'b1, 1'b0, 32'sd0, STATUS_OK}
  };

  kth_smallest_select_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .rank      (rank),
    .last      (last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .selected  (selected),
    .status    (status)
  );

  always #5 clk = ~clk;

  // run limit, far above the slowest correct run
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // insert one value into the sorted set, answer on last
  function automatic void absorb_value(input logic signed [VALUE_W-1:0] v,
                                       input logic [RANK_W-1:0] r, input bit l,
                                       output bit produced, output pick_t res);
    int pos;
    if (sorted_vals.size() >= MAX_ITEMS) begin
      set_overflow = 1'b1;
    end else begin
      pos = sorted_vals.size();
      while (pos > 0 && v < sorted_vals[pos-1]) pos--;
      sorted_vals.insert(pos, v);
    end
    produced = l;
    res.sel = '0;
    res.st = STATUS_OK;
    if (!l) return;
    if (set_overflow) begin
      res.st = STATUS_OVERFLOW;
    end else if (sorted_vals.size() == 0 || r == 0 || r > sorted_vals.size()) begin
      res.st = STATUS_RANGE;
    end else begin
      res.sel = sorted_vals[r-1];
    end
    sorted_vals.delete();
    set_overflow = 1'b0;
  endfunction

  // mostly no gap, some short, a few long
  function automatic int pick_gap(input bit steady);
    int p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0: return VMAX;
      1: return VMIN;
      2, 3: return $signed($urandom_range(0, 6)) - 3;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_size();
    int p;
    p = $urandom_range(0, 99);
    if (p < 72) return $urandom_range(1, 8);
    if (p < 88) return $urandom_range(9, MAX_ITEMS - 1);
    if (p < 94) return MAX_ITEMS;
    return $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
  endfunction

  // mostly a rank inside the set, sometimes zero or past the end
  function automatic logic [RANK_W-1:0] pick_rank(input int n);
    int kept;
    int p;
    kept = (n > MAX_ITEMS) ? MAX_ITEMS : n;
    p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1 && kept < RANK_TOP) return RANK_W'($urandom_range(kept + 1, RANK_TOP));
    return RANK_W'($urandom_range(1, kept));
  endfunction

  // one input transfer, then update the predictor
  task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic [RANK_W-1:0] r,
                           input bit l, input bit typed, input pick_t typed_res);
    int gap;
    bit produced;
    pick_t res;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    rank <= r;
    last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    absorb_value(v, r, l, produced, res);
    if (produced) pending_picks.insert(pending_picks.size(), typed ? typed_res : res);
  endtask

  task automatic send_set(input int n);
    pick_t no_pick;
    bit l;
    no_pick.sel = '0;
    no_pick.st = STATUS_OK;
    for (int i = 0; i < n; i++) begin
      l = (i == n - 1);
      send_item(rand_value(), l ? pick_rank(n) : RANK_W'($urandom_range(0, RANK_TOP)),
                l, 1'b0, no_pick);
    end
  endtask

  // result side: compare every transfer with the oldest expectation
  always @(posedge clk) begin
    pick_t exp_pick;
    if (!rst && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        report_mismatch($sformatf("unexpected result selected=%0d status=%0d",
                                  selected, status));
      end else begin
        exp_pick = pending_picks.pop_front();
        if (selected !== exp_pick.sel)
          report_mismatch($sformatf("selected %0d, expected %0d", selected, exp_pick.sel));
        if (status !== exp_pick.st)
          report_mismatch($sformatf("status %0d, expected %0d", status, exp_pick.st));
      end
    end
  end

  // receiver stalls, with an occasional long hold-off
  initial begin : rx_side
    int len;
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 199) == 0) rx_steady = !rx_steady;
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        len = pick_gap(rx_steady);
        if (len == 0) begin
          out_stall <= 1'b0;
          @(posedge clk);
        end else begin
          out_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end
      end
    end
  end

  // sender: reset, directed sets, then random sets
  initial begin : tx_side
    int n_sets;
    pick_t row_pick;
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    rank = '0;
    last = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row_pick.sel = dir_rows[i].sel;
      row_pick.st = dir_rows[i].st;
      send_item(dir_rows[i].v, dir_rows[i].r, dir_rows[i].l, dir_rows[i].typed, row_pick);
    end

    items_sent = 0;
    n_sets = 0;
    while (items_sent < ITEM_TARGET || n_sets < MIN_SETS) begin
      if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
      // fill the block behind a long receiver hold-off
      if (n_sets == 10 || n_sets == 35) hold_req = 1'b1;
      // let every pending result drain before going on
      if (n_sets == 20 || n_sets == 45) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_picks.size() != 0);
      end
      send_set(pick_size());
      n_sets++;
    end

    // drain and finish
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_picks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
